FILE: design/bounded_uniform_random_integer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded uniform random integer block
// Concurrent property macros that vanish when the design is synthesised.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_UNIFORM_RANDOM_INTEGER_MACROS_SVH
`define BOUNDED_UNIFORM_RANDOM_INTEGER_MACROS_SVH

`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define BUR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Antecedent implies consequent in the following cycle.
`define BUR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define BUR_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define BUR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

FILE: design/bur_pkg.sv
// ----------------------------------------------------------------------------
// Bounded uniform random integer package
// Generator constants, tempering function and shared control types.
// ----------------------------------------------------------------------------
`default_nettype none

package bur_pkg;

   localparam int unsigned MtN = 312;
   localparam int unsigned MtM = 156;
   localparam int unsigned IdxW = 9;
   localparam logic [63:0] MtMatrix   = 64'hB502_6F5A_A966_19E9;
   localparam logic [63:0] MtUpper    = 64'hFFFF_FFFF_8000_0000;
   localparam logic [63:0] MtLower    = 64'h0000_0000_7FFF_FFFF;
   localparam logic [63:0] MtInitMult = 64'd6364136223846793005;
   localparam logic [31:0] SeedReset  = 32'd5489;
   localparam logic [IdxW-1:0] IdxLast = IdxW'(MtN - 1);
   localparam logic [IdxW-1:0] IdxEnd  = IdxW'(MtN);

   // Requests from the sampling controller to the generator.
   typedef struct packed {
      logic        word_req;
      logic        seed_load;
      logic [31:0] seed;
   } gen_ctl_type;

   // A generator word handed back.
   typedef struct packed {
      logic        valid;
      logic [63:0] word;
   } gen_word_type;

   // Result of the bit-serial remainder unit.
   typedef struct packed {
      logic        done;
      logic [32:0] rem;
   } mod_res_type;

   // Output tempering of the 64-bit twister.
   function automatic logic [63:0] temper(input logic [63:0] w);
      logic [63:0] y;
      y = w;
      y = y ^ ((y >> 29) & 64'h5555_5555_5555_5555);
      y = y ^ ((y << 17) & 64'h71D6_7FFF_EDA6_0000);
      y = y ^ ((y << 37) & 64'hFFF7_EEE0_0000_0000);
      y = y ^ (y >> 43);
      return y;
   endfunction

   // Pre-mix of the previous word before the seeding multiply.
   function automatic logic [63:0] seed_mix(input logic [63:0] p);
      return p ^ (p >> 62);
   endfunction

endpackage

`default_nettype wire

FILE: design/bur_channels.sv
// ----------------------------------------------------------------------------
// Bounded uniform random integer channels
// Valid/ready interfaces for requests, results and the seed register.
// ----------------------------------------------------------------------------
`default_nettype none

interface bur_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] low_bound;
   logic signed [31:0] high_bound;
   modport source (output valid, output low_bound, output high_bound, input ready);
   modport sink   (input valid, input low_bound, input high_bound, output ready);
endinterface

interface bur_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] value;
   logic               bad_bounds;
   modport source (output valid, output value, output bad_bounds, input ready);
   modport sink   (input valid, input value, input bad_bounds, output ready);
endinterface

interface bur_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] seed;
   modport source (output valid, output seed, input ready);
   modport sink   (input valid, input seed, output ready);
endinterface

`default_nettype wire

FILE: design/bur_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bur_ram #(
   parameter int unsigned Width = 64,
   parameter int unsigned Depth = 312
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr_a,
   input  wire logic [$clog2(Depth)-1:0] rd_addr_b,
   output logic      [Width-1:0]         rd_data_a,
   output logic      [Width-1:0]         rd_data_b
);

   logic [Width-1:0] mem [Depth];

   // Write and registered reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

`default_nettype wire

FILE: design/bur_twister.sv
// ----------------------------------------------------------------------------
// Twister word generator
// Seeds, regenerates and tempers the 312-word state held in a RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module bur_twister (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bur_pkg::gen_ctl_type ctl,
   output bur_pkg::gen_word_type     word_out
);

   import bur_pkg::*;

   localparam logic [3:0] S_INIT_SEED = 4'd0;
   localparam logic [3:0] S_INIT_MUL  = 4'd1;
   localparam logic [3:0] S_INIT_WR   = 4'd2;
   localparam logic [3:0] S_IDLE      = 4'd3;
   localparam logic [3:0] S_READ      = 4'd4;
   localparam logic [3:0] S_DONE      = 4'd5;
   localparam logic [3:0] S_REG_LD    = 4'd6;
   localparam logic [3:0] S_REG_LD2   = 4'd7;
   localparam logic [3:0] S_REG_RD    = 4'd8;
   localparam logic [3:0] S_REG_WR    = 4'd9;

   logic [3:0]      state_ff, state_in;
   logic [IdxW-1:0] idx_ff, idx_in;
   logic [IdxW-1:0] pos_ff, pos_in;
   logic [2:0]      dcnt_ff, dcnt_in;
   logic [63:0]     acc_ff, acc_in;
   logic [63:0]     xs_ff, xs_in;
   logic [63:0]     cur_ff, cur_in;
   logic [63:0]     word_ff, word_in;

   logic            wr_en;
   logic [IdxW-1:0] wr_addr, rd_addr_a, rd_addr_b;
   logic [63:0]     wr_data, rd_data_a, rd_data_b;
   logic [63:0]     init_word, twist_x, twist_xa;
   logic [IdxW-1:0] idx_next, idx_far;
   logic [IdxW:0]   idx_far_sum;

   bur_ram #(.Width(64), .Depth(MtN)) u_state (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // Neighbouring indexes for the regeneration sweep, wrapping at the end.
   always_comb begin
      idx_next    = (idx_ff == IdxLast) ? '0 : idx_ff + 1'b1;
      idx_far_sum = {1'b0, idx_ff} + (IdxW+1)'(MtM);
      idx_far     = (idx_far_sum >= (IdxW+1)'(MtN)) ?
                    IdxW'(idx_far_sum - (IdxW+1)'(MtN)) : idx_far_sum[IdxW-1:0];
   end

   // Seeding word and twist of one entry.
   always_comb begin
      init_word = acc_ff + {{(64-IdxW){1'b0}}, idx_ff};
      twist_x   = (cur_ff & MtUpper) | (rd_data_a & MtLower);
      twist_xa  = (twist_x >> 1) ^ (twist_x[0] ? MtMatrix : 64'd0);
   end

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      dcnt_in   = dcnt_ff;
      acc_in    = acc_ff;
      xs_in     = xs_ff;
      cur_in    = cur_ff;
      word_in   = word_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = init_word;
      rd_addr_a = pos_ff;
      rd_addr_b = idx_far;
      case (state_ff)
         S_INIT_SEED: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = {32'd0, ctl.seed};
            xs_in    = seed_mix({32'd0, ctl.seed});
            acc_in   = '0;
            dcnt_in  = '0;
            idx_in   = IdxW'(1);
            state_in = S_INIT_MUL;
         end
         S_INIT_MUL: begin
            // Horner form, most significant byte of the multiplier first.
            acc_in  = (acc_ff << 8) + MtInitMult * {56'd0, xs_ff[63:56]};
            xs_in   = xs_ff << 8;
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == 3'd7) begin
               state_in = S_INIT_WR;
            end
         end
         S_INIT_WR: begin
            wr_en   = 1'b1;
            xs_in   = seed_mix(init_word);
            acc_in  = '0;
            dcnt_in = '0;
            idx_in  = idx_ff + 1'b1;
            if (idx_ff == IdxLast) begin
               pos_in   = IdxEnd;
               state_in = S_IDLE;
            end else begin
               state_in = S_INIT_MUL;
            end
         end
         S_IDLE: begin
            if (ctl.word_req) begin
               if (pos_ff == IdxEnd) begin
                  state_in = S_REG_LD;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            word_in  = temper(rd_data_a);
            pos_in   = pos_ff + 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         S_REG_LD: begin
            rd_addr_a = '0;
            idx_in    = '0;
            state_in  = S_REG_LD2;
         end
         S_REG_LD2: begin
            cur_in   = rd_data_a;
            state_in = S_REG_RD;
         end
         S_REG_RD: begin
            rd_addr_a = idx_next;
            rd_addr_b = idx_far;
            state_in  = S_REG_WR;
         end
         S_REG_WR: begin
            wr_en   = 1'b1;
            wr_data = rd_data_b ^ twist_xa;
            cur_in  = rd_data_a;
            idx_in  = idx_next;
            if (idx_ff == IdxLast) begin
               pos_in   = '0;
               state_in = S_IDLE;
            end else begin
               state_in = S_REG_RD;
            end
         end
         default: begin
            state_in = S_INIT_SEED;
         end
      endcase
      if (ctl.seed_load) begin
         state_in = S_INIT_SEED;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT_SEED;
         pos_ff   <= IdxEnd;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
   end

   // Data path registers.
   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      dcnt_ff <= dcnt_in;
      acc_ff  <= acc_in;
      xs_ff   <= xs_in;
      cur_ff  <= cur_in;
      word_ff <= word_in;
   end

   assign word_out.valid = (state_ff == S_DONE);
   assign word_out.word  = word_ff;

endmodule

`default_nettype wire

FILE: design/bur_modulo.sv
// ----------------------------------------------------------------------------
// Bit-serial remainder unit
// Reduces a 64-bit draw modulo a range of up to 2^32, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bur_modulo (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [32:0] divisor,
   output bur_pkg::mod_res_type result
);

   import bur_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] sh_ff, sh_in;
   logic [32:0] rem_ff, rem_in;
   logic [33:0] trial;

   // One restoring step: bring in the next bit and subtract if it fits.
   always_comb begin
      trial   = {rem_ff, sh_ff[63]};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         sh_in   = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            trial = trial - {1'b0, divisor};
         end
         rem_in = trial[32:0];
         sh_in  = sh_ff << 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
   end

   assign result.done = done_ff;
   assign result.rem  = rem_ff;

endmodule

`default_nettype wire

FILE: design/bounded_uniform_random_integer.sv
// ----------------------------------------------------------------------------
// Bounded uniform random integer
// Draws uniform integers between two signed bounds from a 64-bit twister.
// ----------------------------------------------------------------------------
// A request with valid bounds is accepted, a generator word is fetched and
// tempered, the bit-serial remainder by the range is taken, the rejection
// check forms the block start and then tests it, and the result register is
// loaded once the output is free; no new request is taken before then. A
// rejected draw, which is rare, repeats the draw. Once every 312 words the
// generator regenerates its state before that request's word is read. Inverted
// bounds are accepted and go straight to loading the result, without touching
// the generator. After reset and after every seed write the state is rebuilt
// word by word with the byte-serial seeding multiply; requests wait during
// that time.
`default_nettype none

`include "bounded_uniform_random_integer_macros.svh"

module bounded_uniform_random_integer (
   input wire logic clock,
   input wire logic reset,
   bur_req_if.sink   req_bus,
   bur_rsp_if.source rsp_bus,
   bur_csr_if.sink   csr_bus
);

   import bur_pkg::*;

   localparam logic [2:0] T_IDLE = 3'd0;
   localparam logic [2:0] T_DRAW = 3'd1;
   localparam logic [2:0] T_MOD  = 3'd2;
   localparam logic [2:0] T_CHK1 = 3'd3;
   localparam logic [2:0] T_CHK2 = 3'd4;
   localparam logic [2:0] T_PUT  = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [31:0] seed_ff, seed_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_value_ff, rsp_value_in;
   logic        rsp_bad_ff, rsp_bad_in;
   logic [31:0] lo_ff, lo_in;
   logic [32:0] range_ff, range_in;
   logic [63:0] draw_ff, draw_in;
   logic [32:0] rem_ff, rem_in;
   logic [63:0] base_ff, base_in;
   logic [31:0] res_ff, res_in;
   logic        bad_ff, bad_in;

   gen_ctl_type  gen_ctl;
   gen_word_type gen_word;
   mod_res_type  mod_res;
   logic         mod_start;
   logic         req_beat, csr_beat, out_free;
   logic [64:0]  chk_sum;

   bur_twister u_twister (
      .clock    (clock),
      .reset    (reset),
      .ctl      (gen_ctl),
      .word_out (gen_word)
   );

   bur_modulo u_modulo (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (gen_word.word),
      .divisor  (range_ff),
      .result   (mod_res)
   );

   assign req_bus.ready = (state_ff == T_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_beat      = req_bus.valid && req_bus.ready;
   assign csr_beat      = csr_bus.valid && csr_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   // Seed register and generator control.
   always_comb begin
      seed_in           = csr_beat ? csr_bus.seed : seed_ff;
      gen_ctl.seed_load = csr_beat;
      gen_ctl.seed      = seed_in;
      gen_ctl.word_req  = (state_ff == T_DRAW);
   end

   // Request sequencer.
   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      range_in     = range_ff;
      draw_in      = draw_ff;
      rem_in       = rem_ff;
      base_in      = base_ff;
      res_in       = res_ff;
      bad_in       = bad_ff;
      mod_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_value_in = rsp_value_ff;
      rsp_bad_in   = rsp_bad_ff;
      chk_sum      = {1'b0, base_ff} + {32'd0, range_ff};
      case (state_ff)
         T_IDLE: begin
            if (req_beat) begin
               lo_in    = req_bus.low_bound;
               range_in = {req_bus.high_bound[31], req_bus.high_bound}
                        - {req_bus.low_bound[31], req_bus.low_bound} + 33'd1;
               if (req_bus.low_bound > req_bus.high_bound) begin
                  res_in   = req_bus.low_bound;
                  bad_in   = 1'b1;
                  state_in = T_PUT;
               end else begin
                  bad_in   = 1'b0;
                  state_in = T_DRAW;
               end
            end
         end
         T_DRAW: begin
            if (gen_word.valid) begin
               draw_in  = gen_word.word;
               state_in = T_MOD;
            end
         end
         T_MOD: begin
            if (mod_res.done) begin
               rem_in   = mod_res.rem;
               state_in = T_CHK1;
            end
         end
         T_CHK1: begin
            base_in  = draw_ff - {31'd0, rem_ff};
            state_in = T_CHK2;
         end
         T_CHK2: begin
            // The draw lies in the last, partial block of the range when
            // its block start plus the range no longer fits in 64 bits.
            if (chk_sum[64]) begin
               state_in = T_DRAW;
            end else begin
               res_in   = lo_ff + rem_ff[31:0];
               state_in = T_PUT;
            end
         end
         T_PUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               rsp_bad_in   = bad_ff;
               state_in     = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
      if (state_ff == T_DRAW && gen_word.valid) begin
         mod_start = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         seed_ff      <= SeedReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      range_ff     <= range_in;
      draw_ff      <= draw_in;
      rem_ff       <= rem_in;
      base_ff      <= base_in;
      res_ff       <= res_in;
      bad_ff       <= bad_in;
      rsp_value_ff <= rsp_value_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.value      = rsp_value_ff;
   assign rsp_bus.bad_bounds = rsp_bad_ff;

   // The remainder is always below the range it was taken by.
   `BUR_ASSERT_IMPL(a_rem_below_range, clock, reset, state_ff == T_CHK2, rem_ff < range_ff, "remainder not below range")
   // The remainder unit only finishes while a draw is being reduced.
   `BUR_ASSERT_IMPL(a_mod_done_in_mod, clock, reset, mod_res.done, state_ff == T_MOD, "remainder finished outside reduction")
   // An accepted request always leaves the idle state.
   `BUR_ASSERT_NEXT(a_req_leaves_idle, clock, reset, req_beat && !csr_beat, state_ff != T_IDLE, "accepted request left idle")

endmodule

`default_nettype wire
